// ===== design/slp_pkg.sv =====
package slp_pkg;

	localparam int MAX_SPANS = 256;
	localparam int MAX_DIM   = 4096;
	localparam int AW        = $clog2(MAX_SPANS);
	localparam int CW        = $clog2(MAX_SPANS + 1);
	localparam int DW        = 13;
	localparam int WW        = 16;
	localparam int LW        = WW + 2;

	typedef struct packed {
		logic [DW-1:0] x;
		logic [DW-1:0] y;
		logic [WW-1:0] w;
	} span_t;

	localparam int SW = $bits(span_t);

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_EXPAND = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
		logic [DW-1:0] r;
		r = v;
		if (v == '0) r = DW'(1);
		else if (v > DW'(MAX_DIM)) r = DW'(MAX_DIM);
		return r;
	endfunction

endpackage

// ===== design/skyline_rectangle_packer.sv =====
// Latency: clear, expand and the unused code raise done in the cycle after start.
// Allocate reads the spans one at a time: the scan walks each candidate over the spans
// under it, then a rebuild reads every span and writes the new skyline into the
// other bank. One word at a time; busy stays high meanwhile.
// Reset: asynchronous, active low; an init state then writes the root span.
// The receiver cannot stall: done is high for one cycle with the result.
module skyline_rectangle_packer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               operation,
	input  logic [slp_pkg::DW-1:0]   rect_width,
	input  logic [slp_pkg::DW-1:0]   rect_height,
	input  logic [slp_pkg::DW-1:0]   new_width,
	input  logic [slp_pkg::DW-1:0]   new_height,
	output logic                     done,
	output logic [1:0]               status,
	output logic [slp_pkg::DW-1:0]   place_x,
	output logic [slp_pkg::DW-1:0]   place_y,
	output logic [slp_pkg::DW-1:0]   max_level
);

	localparam int DW = slp_pkg::DW;
	localparam int WW = slp_pkg::WW;
	localparam int LW = slp_pkg::LW;
	localparam int AW = slp_pkg::AW;
	localparam int CW = slp_pkg::CW;
	localparam int SW = slp_pkg::SW;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_KRD, S_KDAT, S_WRD, S_WDAT, S_DEC, S_RRD, S_RDAT, S_FLUSH
	} state_t;

	state_t state_q;
	logic bank_q;
	logic [CW-1:0] cnt_q, k_q, idx_q, i_q, wcnt_q;
	logic [DW-1:0] aw_q, ah_q, max_q, rw_q, rh_q, yc_q, cx_q, bx_q, by_q, macc_q;
	logic [DW:0] btop_q;
	logic [WW-1:0] cw_q, bw_q;
	logic signed [LW-1:0] left_q;
	logic [AW-1:0] bk_q;
	logic found_q, ins_q, trim_q, pend_v_q;
	slp_pkg::span_t pend_q;

	logic [1:0] status_q;
	logic [DW-1:0] px_q, py_q;
	logic done_q;

	// memory ports
	logic [SW-1:0] rd0, rd1;
	logic we0, we1;
	logic [AW-1:0] waddr, raddr;
	slp_pkg::span_t wdata, d;

	slp_ram #(.WIDTH(SW), .DEPTH(slp_pkg::MAX_SPANS)) u_bank0 (
		.clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
	);
	slp_ram #(.WIDTH(SW), .DEPTH(slp_pkg::MAX_SPANS)) u_bank1 (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
	);

	assign d = bank_q ? slp_pkg::span_t'(rd1) : slp_pkg::span_t'(rd0);

	logic [DW-1:0] nw_c, nh_c;
	logic grow;
	assign nw_c = slp_pkg::clamp_dim(new_width);
	assign nh_c = slp_pkg::clamp_dim(new_height);
	assign grow = nw_c > aw_q;

	// candidate evaluation
	logic fin, ok, go_walk;
	logic [DW-1:0] cy, ymax, cand_x;
	logic [WW-1:0] cand_w;
	logic signed [LW-1:0] nleft;
	logic [DW:0] top, yh, xr;
	logic better, last_k;

	always_comb begin
		fin = 1'b0;
		ok = 1'b0;
		go_walk = 1'b0;
		cy = '0;
		ymax = d.y;
		nleft = '0;
		xr = {1'b0, d.x} + {1'b0, rw_q};
		if (state_q == S_WDAT) begin
			ymax = (d.y > yc_q) ? d.y : yc_q;
			nleft = left_q - $signed({2'b00, d.w});
		end else begin
			nleft = $signed({{(LW-DW){1'b0}}, rw_q}) - $signed({2'b00, d.w});
		end
		yh = {1'b0, ymax} + {1'b0, rh_q};
		unique case (state_q)
			S_KDAT: begin
				if (xr > {1'b0, aw_q}) begin
					fin = 1'b1;
				end else if (rw_q == '0) begin
					fin = 1'b1;
					ok = 1'b1;
					cy = d.y;
				end else if (yh > {1'b0, ah_q}) begin
					fin = 1'b1;
				end else if (nleft > 0) begin
					go_walk = 1'b1;
				end else begin
					fin = 1'b1;
					ok = 1'b1;
					cy = ymax;
				end
			end
			S_WRD: begin
				if (idx_q >= cnt_q) fin = 1'b1;
			end
			S_WDAT: begin
				if (yh > {1'b0, ah_q}) begin
					fin = 1'b1;
				end else if (nleft > 0) begin
					go_walk = 1'b1;
				end else begin
					fin = 1'b1;
					ok = 1'b1;
					cy = ymax;
				end
			end
			default: ;
		endcase
		cand_x = (state_q == S_KDAT) ? d.x : cx_q;
		cand_w = (state_q == S_KDAT) ? d.w : cw_q;
		top = {1'b0, cy} + {1'b0, rh_q};
		better = ok && (top < btop_q || (top == btop_q && cand_w < bw_q));
		last_k = (k_q + CW'(1)) == cnt_q;
	end

	// rebuild stream: insert, trim shadowed spans, merge equal neighbors
	logic ins_now, emit, trim_off, merge, pwr;
	logic [DW:0] edge_x;
	logic signed [LW-1:0] twid;
	slp_pkg::span_t e;

	always_comb begin
		edge_x = {1'b0, bx_q} + {1'b0, rw_q};
		twid = $signed({2'b00, d.w}) - $signed({{(LW-DW-1){1'b0}}, edge_x})
			+ $signed({{(LW-DW){1'b0}}, d.x});
		ins_now = (state_q == S_RDAT) && !ins_q && (i_q == CW'(bk_q));
		emit = 1'b0;
		trim_off = 1'b0;
		e = d;
		if (state_q == S_RDAT) begin
			if (ins_now) begin
				emit = 1'b1;
				e.x = bx_q;
				e.y = btop_q[DW-1:0];
				e.w = WW'(rw_q);
			end else if (trim_q) begin
				if ({1'b0, d.x} >= edge_x) begin
					emit = 1'b1;
					trim_off = 1'b1;
				end else if (twid > 0) begin
					emit = 1'b1;
					trim_off = 1'b1;
					e.x = edge_x[DW-1:0];
					e.w = twid[WW-1:0];
				end
			end else begin
				emit = 1'b1;
			end
		end
		merge = pend_v_q && (pend_q.y == e.y);
		pwr = (emit && pend_v_q && !merge) || (state_q == S_FLUSH);
	end

	// write port steering
	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		waddr = '0;
		wdata = pend_q;
		raddr = i_q[AW-1:0];
		if (state_q == S_KRD) raddr = k_q[AW-1:0];
		else if (state_q == S_WRD) raddr = idx_q[AW-1:0];
		priority if (state_q == S_INIT) begin
			we0 = 1'b1;
			wdata = '{x: '0, y: '0, w: WW'(slp_pkg::MAX_DIM)};
		end else if (state_q == S_IDLE && start && operation == slp_pkg::OP_CLEAR) begin
			we0 = !bank_q;
			we1 = bank_q;
			wdata = '{x: '0, y: '0, w: WW'(nw_c)};
		end else if (state_q == S_IDLE && start && operation == slp_pkg::OP_EXPAND
			&& grow && cnt_q < CW'(slp_pkg::MAX_SPANS)) begin
			we0 = !bank_q;
			we1 = bank_q;
			waddr = cnt_q[AW-1:0];
			wdata = '{x: aw_q, y: '0, w: WW'(nw_c - aw_q)};
		end else if (pwr) begin
			// rebuild writes into the idle bank
			we0 = bank_q;
			we1 = !bank_q;
			waddr = wcnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			bank_q <= 1'b0;
			cnt_q <= CW'(1);
			aw_q <= DW'(slp_pkg::MAX_DIM);
			ah_q <= DW'(slp_pkg::MAX_DIM);
			max_q <= '0;
			done_q <= 1'b0;
			status_q <= slp_pkg::ST_OK;
			px_q <= '0;
			py_q <= '0;
			found_q <= 1'b0;
			ins_q <= 1'b0;
			trim_q <= 1'b0;
			pend_v_q <= 1'b0;
			k_q <= '0;
			idx_q <= '0;
			i_q <= '0;
			wcnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (start) begin
						rw_q <= rect_width;
						rh_q <= rect_height;
						status_q <= slp_pkg::ST_OK;
						px_q <= '0;
						py_q <= '0;
						unique case (slp_pkg::op_t'(operation))
							slp_pkg::OP_ALLOC: begin
								k_q <= '0;
								found_q <= 1'b0;
								btop_q <= {1'b0, ah_q};
								bw_q <= WW'(aw_q);
								state_q <= S_KRD;
							end
							slp_pkg::OP_CLEAR: begin
								aw_q <= nw_c;
								ah_q <= nh_c;
								cnt_q <= CW'(1);
								max_q <= '0;
								done_q <= 1'b1;
							end
							slp_pkg::OP_EXPAND: begin
								if (grow && cnt_q >= CW'(slp_pkg::MAX_SPANS)) begin
									status_q <= slp_pkg::ST_FULL;
								end else begin
									if (grow) cnt_q <= cnt_q + CW'(1);
									aw_q <= nw_c;
									ah_q <= nh_c;
								end
								done_q <= 1'b1;
							end
							slp_pkg::OP_NONE: done_q <= 1'b1;
						endcase
					end
				end
				S_KRD: state_q <= S_KDAT;
				S_KDAT, S_WRD, S_WDAT: begin
					if (state_q == S_KDAT) begin
						cx_q <= d.x;
						cw_q <= d.w;
						idx_q <= k_q + CW'(1);
					end
					if (state_q == S_WDAT) idx_q <= idx_q + CW'(1);
					if (state_q == S_WRD && !fin) begin
						state_q <= S_WDAT;
					end else if (go_walk) begin
						yc_q <= ymax;
						left_q <= nleft;
						state_q <= S_WRD;
					end else if (fin) begin
						if (better) begin
							found_q <= 1'b1;
							bk_q <= k_q[AW-1:0];
							bw_q <= cand_w;
							btop_q <= top;
							bx_q <= cand_x;
							by_q <= cy;
						end
						k_q <= k_q + CW'(1);
						state_q <= last_k ? S_DEC : S_KRD;
					end
				end
				S_DEC: begin
					if (!found_q) begin
						status_q <= slp_pkg::ST_NOFIT;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (cnt_q >= CW'(slp_pkg::MAX_SPANS)) begin
						status_q <= slp_pkg::ST_FULL;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q <= '0;
						wcnt_q <= '0;
						ins_q <= 1'b0;
						trim_q <= 1'b0;
						pend_v_q <= 1'b0;
						macc_q <= '0;
						state_q <= S_RRD;
					end
				end
				S_RRD: state_q <= S_RDAT;
				S_RDAT: begin
					if (emit) begin
						if (merge) begin
							pend_q.w <= pend_q.w + e.w;
						end else begin
							pend_q <= e;
							pend_v_q <= 1'b1;
						end
					end
					if (pwr) begin
						wcnt_q <= wcnt_q + CW'(1);
						if (pend_q.y > macc_q) macc_q <= pend_q.y;
					end
					if (ins_now) begin
						ins_q <= 1'b1;
						trim_q <= 1'b1;
					end else begin
						if (trim_off) trim_q <= 1'b0;
						i_q <= i_q + CW'(1);
						state_q <= ((i_q + CW'(1)) == cnt_q) ? S_FLUSH : S_RRD;
					end
				end
				S_FLUSH: begin
					cnt_q <= wcnt_q + CW'(1);
					max_q <= (pend_q.y > macc_q) ? pend_q.y : macc_q;
					bank_q <= !bank_q;
					px_q <= bx_q;
					py_q <= by_q;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign status = status_q;
	assign place_x = px_q;
	assign place_y = py_q;
	assign max_level = max_q;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CW'(slp_pkg::MAX_SPANS))
		else $error("span count out of range");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != slp_pkg::ST_OK |-> place_x == '0 && place_y == '0)
		else $error("failed word carries a position");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted word neither busy nor done");
	a_done_past: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("done without work");
`endif

endmodule

// ===== design/slp_ram.sv =====
module slp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
